[design/dac_pkg.sv]
// Shared types and constants for the drag coefficient atmospheric correction.
package dac_pkg;

  localparam int D_W   = 18;
  localparam int ALT_W = 16;
  localparam int P_W   = 12;
  localparam int T_W   = 12;
  localparam int H_W   = 10;

  // Operand widths of the three fixed-point divisions.
  localparam int FA_NUM_W = 50;
  localparam int FA_DEN_W = 53;
  localparam int FT_NUM_W = 36;
  localparam int FT_DEN_W = 34;
  localparam int FR_NUM_W = 59;
  localparam int FR_DEN_W = 60;

  localparam logic [FA_NUM_W-1:0] FA_NUM = 50'd1000000000000000;

  localparam int DIV_STEPS  = 64;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int MUL_LAT    = 6;
  localparam int FIFO_DEPTH = 2;

  localparam logic [D_W-1:0] OUT_MAX = 18'h3FFFF;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_CLIP,
    CLS_ZERO
  } cls_t;

  typedef struct packed {
    logic [D_W-1:0]      d;
    logic [FA_DEN_W-1:0] den_fa;
    logic [FT_NUM_W-1:0] num_ft;
    logic [FT_DEN_W-1:0] den_ft;
    logic [FR_NUM_W-1:0] num_fr;
    logic [FR_DEN_W-1:0] den_fr;
    cls_t                cls;
  } front_word_t;

endpackage

[design/dac_div.sv]
// Pipelined restoring divider giving a rounded fixed-point quotient with saturation.
module dac_div #(
  parameter int NUM_W     = 50,
  parameter int DEN_W     = 53,
  parameter int FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [63:0]      quo
);
  import dac_pkg::*;

  localparam int SHIFT = 63 - FRAC_BITS;
  localparam int RW    = DEN_W + 1;

  logic [63:0]      num64;
  logic [63:0]      hi;
  logic [DEN_W-1:0] rem_r [DIV_STEPS+1];
  logic [63:0]      w_r   [DIV_STEPS+1];
  logic [DEN_W-1:0] den_r [DIV_STEPS+1];
  logic             sat_r [DIV_STEPS+1];
  logic [63:0]      quo_r;

  assign num64 = 64'(num);
  assign hi    = num64 >> SHIFT;

  // The integer quotient overflows exactly when the top part of the numerator reaches den.
  always_ff @(posedge clk) begin
    rem_r[0] <= DEN_W'(hi);
    w_r[0]   <= num64 << (FRAC_BITS + 1);
    den_r[0] <= den;
    sat_r[0] <= (hi >= 64'(den));
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {rem_r[k-1], w_r[k-1][63]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_r[k-1]}) : DEN_W'(trial);
      w_r[k]   <= {w_r[k-1][62:0], ge};
      den_r[k] <= den_r[k-1];
      sat_r[k] <= sat_r[k-1];
    end
  end

  // The quotient carries one extra fraction bit, which rounds half up.
  always_ff @(posedge clk) begin
    if (sat_r[DIV_STEPS]) begin
      quo_r <= '1;
    end else begin
      quo_r <= 64'((65'(w_r[DIV_STEPS]) + 65'd1) >> 1);
    end
  end

  assign quo = quo_r;

endmodule

[design/dac_mul.sv]
// Pipelined 64 by 64 fixed-point multiplier built from 32-bit partial products.
module dac_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  import dac_pkg::*;

  localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

  logic [63:0]  pr1_r, pr2_r, pr3_r, pr4_r;
  logic [63:0]  a1_r, b1_r, a2_r, b2_r;
  logic [31:0]  ah3_r, bh3_r;
  logic [127:0] acc2_r, acc3_r, acc4_r, acc5_r;
  logic [127:0] sum;
  logic [63:0]  p_r;

  assign sum = acc5_r + HALF;

  always_ff @(posedge clk) begin
    pr1_r  <= 64'(a[31:0]) * 64'(b[31:0]);
    a1_r   <= a;
    b1_r   <= b;
    acc2_r <= 128'(pr1_r);
    pr2_r  <= 64'(a1_r[31:0]) * 64'(b1_r[63:32]);
    a2_r   <= a1_r;
    b2_r   <= b1_r;
    acc3_r <= acc2_r + (128'(pr2_r) << 32);
    pr3_r  <= 64'(a2_r[63:32]) * 64'(b2_r[31:0]);
    ah3_r  <= a2_r[63:32];
    bh3_r  <= b2_r[63:32];
    acc4_r <= acc3_r + (128'(pr3_r) << 32);
    pr4_r  <= 64'(ah3_r) * 64'(bh3_r);
    acc5_r <= acc4_r + (128'(pr4_r) << 64);
    if ((sum >> (64 + FRAC_BITS)) != '0) begin
      p_r <= '1;
    end else begin
      p_r <= sum[FRAC_BITS +: 64];
    end
  end

  assign p = p_r;

endmodule

[design/dac_front.sv]
// Front end: captures a word and evaluates the polynomial terms, then classifies it.
module dac_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [dac_pkg::D_W-1:0]    drag_coeff,
  input  logic [dac_pkg::ALT_W-1:0]  altitude_ft,
  input  logic [dac_pkg::P_W-1:0]    pressure_centi_inhg,
  input  logic signed [dac_pkg::T_W-1:0] temp_deci_f,
  input  logic [dac_pkg::H_W-1:0]    humidity_permille,
  output logic                       push_valid,
  output dac_pkg::front_word_t       push_word
);
  import dac_pkg::*;

  logic [7:0] v_r;

  // stage 0
  logic [ALT_W-1:0]      a0_r;
  logic signed [T_W-1:0] t0_r;
  logic [P_W-1:0]        p0_r;
  logic [H_W-1:0]        h0_r;
  logic [D_W-1:0]        d0_r;
  // stage 1
  logic [ALT_W-1:0]      a1_r;
  logic signed [T_W-1:0] t1_r;
  logic [P_W-1:0]        p1_r;
  logic [D_W-1:0]        d1_r;
  logic [18:0]           c1_nxt, c1_r;
  logic signed [14:0]    e1_nxt, e1_r;
  logic [21:0]           hv_nxt, hv1_r;
  logic [21:0]           a36;
  logic [22:0]           dt_nxt, dt1_r;
  logic signed [22:0]    nt_nxt, nt1_r;
  logic [12:0]           pm_nxt, pm1_r;
  // stage 2
  logic [ALT_W-1:0]      a2_r;
  logic signed [T_W-1:0] t2_r;
  logic [P_W-1:0]        p2_r;
  logic [D_W-1:0]        d2_r;
  logic [21:0]           hv2_r;
  logic [34:0]           pa1_r;
  logic signed [25:0]    qa1_r;
  logic [34:0]           nsa_r;
  logic signed [34:0]    nsb_r;
  logic [33:0]           ds2_r;
  // stage 3
  logic [ALT_W-1:0]      a3_r;
  logic signed [T_W-1:0] t3_r;
  logic [P_W-1:0]        p3_r;
  logic [D_W-1:0]        d3_r;
  logic [21:0]           hv3_r;
  logic [33:0]           ds3_r;
  logic signed [36:0]    c2_r;
  logic signed [26:0]    e2_r;
  logic signed [36:0]    ns3_r;
  // stage 4
  logic [P_W-1:0]        p4_r;
  logic [D_W-1:0]        d4_r;
  logic [21:0]           hv4_r;
  logic [33:0]           ds4_r;
  logic signed [36:0]    ns4_r;
  logic signed [53:0]    pa2_r;
  logic signed [36:0]    qa2_r;
  // stage 5
  logic [P_W-1:0]        p5_r;
  logic [D_W-1:0]        d5_r;
  logic [21:0]           hv5_r;
  logic [33:0]           ds5_r;
  logic signed [36:0]    ns5_r;
  logic signed [53:0]    fa5_r;
  logic signed [36:0]    v9_r;
  // stage 6
  logic [D_W-1:0]        d6_r;
  logic [33:0]           ds6_r;
  logic signed [36:0]    ns6_r;
  logic signed [53:0]    fa6_r;
  logic signed [58:0]    rr_r;
  logic [58:0]           pp_r;
  logic [58:0]           num3_r;
  // stage 7
  logic signed [60:0]    dfr;
  logic                  clip, zero;
  front_word_t           word_nxt, word_r;

  assign c1_nxt = 19'd400000 - {1'b0, a0_r, 2'b00};
  assign e1_nxt = $signed({t0_r[T_W-1], t0_r, 2'b00}) - 15'sd4000;
  assign hv_nxt = 22'(h0_r) * 22'd3783;
  assign a36    = 22'(a0_r) * 22'd36;
  assign dt_nxt = 23'd5186000 - {1'b0, a36};
  assign nt_nxt = 23'(t0_r) * 23'sd1000 - 23'sd590000 + $signed({1'b0, a36});
  assign pm_nxt = 13'd5906 - {1'b0, p0_r};

  // Either denominator at or below zero clips; otherwise a nonpositive factor gives zero.
  assign dfr  = $signed({2'b00, pp_r}) - 61'(rr_r);
  assign clip = (fa6_r <= 54'sd0) || (dfr <= 61'sd0);
  assign zero = (ns6_r <= 37'sd0);

  always_comb begin
    word_nxt.d      = d6_r;
    word_nxt.den_fa = clip ? 53'd1 : fa6_r[FA_DEN_W-1:0];
    word_nxt.num_ft = (clip || zero) ? '0 : ns6_r[FT_NUM_W-1:0];
    word_nxt.den_ft = ds6_r;
    word_nxt.num_fr = num3_r;
    word_nxt.den_fr = clip ? 60'd1 : dfr[FR_DEN_W-1:0];
    if (clip) begin
      word_nxt.cls = CLS_CLIP;
    end else if (zero) begin
      word_nxt.cls = CLS_ZERO;
    end else begin
      word_nxt.cls = CLS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a0_r <= altitude_ft;
      t0_r <= temp_deci_f;
      p0_r <= pressure_centi_inhg;
      h0_r <= humidity_permille;
      d0_r <= drag_coeff;
    end
    a1_r  <= a0_r;
    t1_r  <= t0_r;
    p1_r  <= p0_r;
    d1_r  <= d0_r;
    c1_r  <= c1_nxt;
    e1_r  <= e1_nxt;
    hv1_r <= hv_nxt;
    dt1_r <= dt_nxt;
    nt1_r <= nt_nxt;
    pm1_r <= pm_nxt;

    a2_r  <= a1_r;
    t2_r  <= t1_r;
    p2_r  <= p1_r;
    d2_r  <= d1_r;
    hv2_r <= hv1_r;
    pa1_r <= 35'(a1_r) * 35'(c1_r);
    qa1_r <= 26'(t1_r) * 26'(e1_r);
    nsa_r <= 35'(dt1_r) * 35'(pm1_r);
    nsb_r <= 35'(nt1_r) * 35'sd2953;
    ds2_r <= 34'(dt1_r) * 34'd2953;

    a3_r  <= a2_r;
    t3_r  <= t2_r;
    p3_r  <= p2_r;
    d3_r  <= d2_r;
    hv3_r <= hv2_r;
    ds3_r <= ds2_r;
    c2_r  <= $signed({2'b00, pa1_r}) - 37'sd30000000000;
    e2_r  <= 27'(qa1_r) + 27'sd2340000;
    ns3_r <= $signed({2'b00, nsa_r}) + 37'(nsb_r);

    p4_r  <= p3_r;
    d4_r  <= d3_r;
    hv4_r <= hv3_r;
    ds4_r <= ds3_r;
    ns4_r <= ns3_r;
    pa2_r <= 54'($signed({1'b0, a3_r})) * 54'(c2_r);
    qa2_r <= 37'(t3_r) * 37'(e2_r);

    p5_r  <= p4_r;
    d5_r  <= d4_r;
    hv5_r <= hv4_r;
    ds5_r <= ds4_r;
    ns5_r <= ns4_r;
    fa5_r <= pa2_r + 54'sd1000000000000000;
    v9_r  <= qa2_r - 37'sd251700000;

    d6_r   <= d5_r;
    ds6_r  <= ds5_r;
    ns6_r  <= ns5_r;
    fa6_r  <= fa5_r;
    rr_r   <= 59'($signed({1'b0, hv5_r})) * 59'(v9_r);
    pp_r   <= 59'(p5_r) * 59'd100000000000000;
    num3_r <= 59'(p5_r) * 59'd99500000000000;

    word_r <= word_nxt;
  end

  assign push_valid = v_r[7];
  assign push_word  = word_r;

endmodule

[design/dac_fifo.sv]
// Short queue between the front end and the back end.
module dac_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  dac_pkg::front_word_t push_word,
  output logic                 full,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output dac_pkg::front_word_t rd_word
);
  import dac_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  front_word_t      mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign full     = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem_r[rd_ptr_r];
  assign push     = push_valid && !full;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

[design/dac_back.sv]
// Back end: the three factor divisions, the product chain and final rounding.
module dac_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  dac_pkg::front_word_t    in_word,
  output logic                    out_strobe,
  output logic [dac_pkg::D_W-1:0] out_coeff,
  output logic                    out_sat
);
  import dac_pkg::*;

  localparam int CTRL_LAT = DIV_LAT + 3 * MUL_LAT;
  localparam int SH       = FRAC_BITS - 16;
  localparam logic [64:0] HALF = (65'd1 << SH) >> 1;

  logic        b0_v_r;
  front_word_t b0_word_r;
  logic [63:0] q_fa, q_ft, q_fr;
  logic [63:0] v0, v1, v2, v3;
  logic [D_W-1:0] d_line_r  [DIV_LAT];
  logic [63:0]    ft_line_r [MUL_LAT];
  logic [63:0]    fr_line_r [2*MUL_LAT];
  logic           vld_line_r [CTRL_LAT];
  cls_t           cls_line_r [CTRL_LAT];
  logic [64:0]    sum;
  logic [64:0]    res;
  logic           over;
  logic           strobe_r;
  logic [D_W-1:0] coeff_nxt, coeff_r;
  logic           sat_nxt, sat_r;

  // The queue is drained every cycle; nothing downstream can stall.
  assign in_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
    end else begin
      b0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      b0_word_r <= in_word;
    end
  end

  dac_div #(.NUM_W(FA_NUM_W), .DEN_W(FA_DEN_W), .FRAC_BITS(FRAC_BITS)) u_div_fa (
    .clk (clk),
    .num (FA_NUM),
    .den (b0_word_r.den_fa),
    .quo (q_fa)
  );

  dac_div #(.NUM_W(FT_NUM_W), .DEN_W(FT_DEN_W), .FRAC_BITS(FRAC_BITS)) u_div_ft (
    .clk (clk),
    .num (b0_word_r.num_ft),
    .den (b0_word_r.den_ft),
    .quo (q_ft)
  );

  dac_div #(.NUM_W(FR_NUM_W), .DEN_W(FR_DEN_W), .FRAC_BITS(FRAC_BITS)) u_div_fr (
    .clk (clk),
    .num (b0_word_r.num_fr),
    .den (b0_word_r.den_fr),
    .quo (q_fr)
  );

  // Delay lines line each operand up with its place in the product chain.
  always_ff @(posedge clk) begin
    d_line_r[0] <= b0_word_r.d;
    for (int i = 1; i < DIV_LAT; i++) begin
      d_line_r[i] <= d_line_r[i-1];
    end
    ft_line_r[0] <= q_ft;
    for (int i = 1; i < MUL_LAT; i++) begin
      ft_line_r[i] <= ft_line_r[i-1];
    end
    fr_line_r[0] <= q_fr;
    for (int i = 1; i < 2 * MUL_LAT; i++) begin
      fr_line_r[i] <= fr_line_r[i-1];
    end
    cls_line_r[0] <= b0_word_r.cls;
    for (int i = 1; i < CTRL_LAT; i++) begin
      cls_line_r[i] <= cls_line_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTRL_LAT; i++) begin
        vld_line_r[i] <= 1'b0;
      end
    end else begin
      vld_line_r[0] <= b0_v_r;
      for (int i = 1; i < CTRL_LAT; i++) begin
        vld_line_r[i] <= vld_line_r[i-1];
      end
    end
  end

  assign v0 = 64'(d_line_r[DIV_LAT-1]) << SH;

  dac_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fa (
    .clk (clk),
    .a   (v0),
    .b   (q_fa),
    .p   (v1)
  );

  dac_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ft (
    .clk (clk),
    .a   (v1),
    .b   (ft_line_r[MUL_LAT-1]),
    .p   (v2)
  );

  dac_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fr (
    .clk (clk),
    .a   (v2),
    .b   (fr_line_r[2*MUL_LAT-1]),
    .p   (v3)
  );

  // A carry out of the rounding add counts as overflow, like a result above OUT_MAX.
  assign sum  = {1'b0, v3} + HALF;
  assign res  = sum >> SH;
  assign over = sum[64] || (res > 65'(OUT_MAX));

  always_comb begin
    case (cls_line_r[CTRL_LAT-1])
      CLS_CLIP: begin
        coeff_nxt = OUT_MAX;
        sat_nxt   = 1'b1;
      end
      CLS_ZERO: begin
        coeff_nxt = '0;
        sat_nxt   = 1'b0;
      end
      default: begin
        coeff_nxt = over ? OUT_MAX : res[D_W-1:0];
        sat_nxt   = over;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_line_r[CTRL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    coeff_r <= coeff_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_coeff  = coeff_r;
  assign out_sat    = sat_r;

endmodule

[design/drag_atmospheric_correction.sv]
// out_strobe flags each result after its word passes the front and back end.
// Throughput: one word per cycle; every unit is fully pipelined, the dividers
// resolve one quotient bit per stage over 64 stages and each product takes six.
// busy stays low in operation since the back end drains the queue every cycle.
// Reset is synchronous and active low; it clears the valid pipeline and queue
// pointers, data registers are not cleared.
module drag_atmospheric_correction #(
  parameter int FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dac_pkg::D_W-1:0]        in_drag_coeff,
  input  logic [dac_pkg::ALT_W-1:0]      in_altitude_ft,
  input  logic [dac_pkg::P_W-1:0]        in_pressure_centi_inhg,
  input  logic signed [dac_pkg::T_W-1:0] in_temp_deci_f,
  input  logic [dac_pkg::H_W-1:0]        in_humidity_permille,
  output logic                           out_strobe,
  output logic [dac_pkg::D_W-1:0]        out_corrected_coeff,
  output logic                           out_saturated
);
  import dac_pkg::*;

  logic        accept;
  logic        push_valid;
  front_word_t push_word;
  logic        full;
  logic        rd_valid;
  logic        rd_ready;
  front_word_t rd_word;

  assign busy   = full;
  assign accept = start && !busy;

  dac_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .drag_coeff          (in_drag_coeff),
    .altitude_ft         (in_altitude_ft),
    .pressure_centi_inhg (in_pressure_centi_inhg),
    .temp_deci_f         (in_temp_deci_f),
    .humidity_permille   (in_humidity_permille),
    .push_valid          (push_valid),
    .push_word           (push_word)
  );

  dac_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .full       (full),
    .rd_valid   (rd_valid),
    .rd_ready   (rd_ready),
    .rd_word    (rd_word)
  );

  dac_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rd_valid),
    .in_ready   (rd_ready),
    .in_word    (rd_word),
    .out_strobe (out_strobe),
    .out_coeff  (out_corrected_coeff),
    .out_sat    (out_saturated)
  );

endmodule

[verif/drag_atmospheric_correction_checker.sv]
// Checker for the drag coefficient correction: predicts each result and compares it.
`timescale 1ns / 100ps
module drag_atmospheric_correction_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [dac_pkg::D_W-1:0]        in_drag_coeff,
  input  logic [dac_pkg::ALT_W-1:0]      in_altitude_ft,
  input  logic [dac_pkg::P_W-1:0]        in_pressure_centi_inhg,
  input  logic signed [dac_pkg::T_W-1:0] in_temp_deci_f,
  input  logic [dac_pkg::H_W-1:0]        in_humidity_permille,
  input  logic                           out_strobe,
  input  logic [dac_pkg::D_W-1:0]        out_corrected_coeff,
  input  logic                           out_saturated,
  output int                             fail_count,
  output int                             pending_count,
  output int                             clip_count,
  output int                             result_count
);
  import dac_pkg::*;

  localparam int FB = 24;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [D_W-1:0] coeff;
    logic           sat;
  } corr_word_t;

  corr_word_t corr_queue[$];

  // Quotient with FB fractional bits, rounded half up; saturates when too wide.
  function automatic logic [63:0] fixed_quot(logic [63:0] num, logic [63:0] den);
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] r;
    if ((num / den) >> (63 - FB) != 0) return ALL_ONES;
    n = {64'd0, num} << FB;
    q = n / den;
    r = n % den;
    if ((r << 1) >= den) q = q + 1;
    return q[63:0];
  endfunction

  function automatic logic [63:0] fixed_prod(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (FB - 1));
    if ((p >> (64 + FB)) != 0) return ALL_ONES;
    return p[FB +: 64];
  endfunction

  function automatic corr_word_t correct_coeff(logic [D_W-1:0] d, logic [ALT_W-1:0] alt,
                                               logic [P_W-1:0] pr, logic signed [T_W-1:0] tp,
                                               logic [H_W-1:0] hum);
    longint a, p, t, h, fa, vp, dfr, nt, dt, ns, ds;
    logic [63:0] v;
    corr_word_t w;
    a = alt; p = pr; t = tp; h = hum;
    fa = 64'sd1000000000000000 - 64'sd30000000000 * a + 64'sd400000 * a * a
         - 64'sd4 * a * a * a;
    vp = 64'sd4 * t * t * t - 64'sd4000 * t * t + 64'sd2340000 * t - 64'sd251700000;
    dfr = p * 64'sd100000000000000 - 64'sd3783 * h * vp;
    if (fa <= 0 || dfr <= 0) begin
      w.coeff = OUT_MAX; w.sat = 1'b1;
      return w;
    end
    nt = 64'sd1000 * t - 64'sd590000 + 64'sd36 * a;
    dt = 64'sd5186000 - 64'sd36 * a;
    ns = 64'sd2 * dt * 64'sd2953 + nt * 64'sd2953 - p * dt;
    ds = dt * 64'sd2953;
    if (ns <= 0) begin
      w.coeff = '0; w.sat = 1'b0;
      return w;
    end
    v = {46'd0, d} << (FB - 16);
    v = fixed_prod(v, fixed_quot(64'd1000000000000000, fa));
    v = fixed_prod(v, fixed_quot(ns, ds));
    v = fixed_prod(v, fixed_quot(64'd99500000000000 * p, dfr));
    if (v > ALL_ONES - 64'd128) v = ALL_ONES;
    else v = (v + 64'd128) >> 8;
    w.sat = v > OUT_MAX;
    w.coeff = w.sat ? OUT_MAX : v[D_W-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0; clip_count = 0; result_count = 0; pending_count = 0;
  end

  always @(posedge clk) begin
    corr_word_t want;
    if (rst_n && start && !busy)
      corr_queue.push_back(correct_coeff(in_drag_coeff, in_altitude_ft,
        in_pressure_centi_inhg, in_temp_deci_f, in_humidity_permille));
    if (rst_n && out_strobe) begin
      result_count++;
      if (corr_queue.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = corr_queue.pop_front();
        if (want.sat) clip_count++;
        if (out_corrected_coeff !== want.coeff)
          report_mismatch($sformatf("corrected_coeff %0h, expected %0h",
                                    out_corrected_coeff, want.coeff));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("saturated %b, expected %b", out_saturated, want.sat));
      end
    end
    pending_count = corr_queue.size();
  end

endmodule

[verif/drag_atmospheric_correction_tb.sv]
// Testbench top for the drag coefficient correction: stimulus, timeout and verdict.
`timescale 1ns / 100ps
module drag_atmospheric_correction_tb;
  import dac_pkg::*;

  localparam int N_RANDOM = 1400;
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [D_W-1:0]          in_drag_coeff = '0;
  logic [ALT_W-1:0]        in_altitude_ft = '0;
  logic [P_W-1:0]          in_pressure_centi_inhg = '0;
  logic signed [T_W-1:0]   in_temp_deci_f = '0;
  logic [H_W-1:0]          in_humidity_permille = '0;
  logic                    out_strobe;
  logic [D_W-1:0]          out_corrected_coeff;
  logic                    out_saturated;
  int                      fail_count, pending_count, clip_count, result_count;
  int                      cycle_count = 0;
  int                      idle_pct = 0;
  int                      sent_words = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  drag_atmospheric_correction DUT (.*);

  drag_atmospheric_correction_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[drag_atmospheric_correction] ERROR");
      $finish;
    end
  end

  // Offers one word, holding it until accepted, with random idle cycles first.
  task automatic send_word(logic [D_W-1:0] d, logic [ALT_W-1:0] a, logic [P_W-1:0] p,
                           logic signed [T_W-1:0] t, logic [H_W-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_drag_coeff <= d; in_altitude_ft <= a; in_pressure_centi_inhg <= p;
    in_temp_deci_f <= t; in_humidity_permille <= h;
    do @(posedge clk); while (busy);
    sent_words++;
  endtask

  task automatic send_random;
    if ($urandom_range(99) < 15)
      send_word(D_W'($urandom), ALT_W'($urandom), P_W'($urandom),
                $signed(T_W'($urandom)), H_W'($urandom));
    else
      send_word(D_W'($urandom), ALT_W'($urandom_range(40000)),
                P_W'($urandom_range(3500, 1500)),
                $signed(T_W'($urandom_range(2000) - 600)), H_W'($urandom_range(1000)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Corners of each field, the clipping cases and a try at a negative factor.
    send_word('0, 0, 2953, 590, 0);
    send_word('1, 0, 2953, 590, 0);
    send_word('1, 40000, 1500, -600, 1000);
    send_word(18'h10000, 40000, 3500, 1400, 1000);
    send_word(18'h10000, 0, 3500, -600, 0);
    send_word(18'h2ABCD, 65535, 2953, 590, 500);
    send_word(18'h15432, 30000, 2953, 590, 500);
    send_word(18'h10000, 0, 500, 2047, 1023);
    send_word(18'h10000, 0, 0, 0, 0);
    send_word(18'h10000, 0, 4095, -2048, 0);
    send_word(18'h3FFFF, 60000, 4095, -2048, 1023);
    send_word(18'h3FFFF, 0, 1500, 2047, 1023);
    send_word(18'h00001, 12345, 2992, 700, 800);
    send_word(18'h2AAAA, 21845, 12'hAAA, 12'h555, 10'h2AA);
    send_word(18'h15555, 43690, 12'h555, 12'hAAA, 10'h155);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 49 : (ph == 2) ? 0 : 31;
      for (int i = 0; i < N_RANDOM / 4; i++) send_random();
    end
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Sent %0d words over idle phases of 0, 49 and 31 percent; %0d results checked,",
             sent_words, result_count);
    $display("%0d of them clipped at the maximum.", clip_count);
    if (fail_count == 0) begin
      $display("[drag_atmospheric_correction] OK");
    end else begin
      $display("[drag_atmospheric_correction] ERROR");
    end
    $finish;
  end

endmodule
